/* hdl/vfcm_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// vfcm_pkg
// Shared sizes, operation codes and the face corner table of the voxel
// face culling mesher.
// ----------------------------------------------------------------------------
package vfcm_pkg;

	localparam int SIZE_X = 32;
	localparam int SIZE_Y = 32;
	localparam int SIZE_Z = 32;

	// occupancy is kept as one row of SIZE_X bits for each (y, z)
	localparam int ROWS  = SIZE_Y * SIZE_Z;
	localparam int RA_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int XI_W  = (SIZE_X > 1) ? $clog2(SIZE_X) : 1;
	localparam int CNT_W = 20;

	localparam logic [1:0] OP_WRITE   = 2'd0;
	localparam logic [1:0] OP_MESH    = 2'd1;
	localparam logic [1:0] OP_CLEAR   = 2'd2;
	localparam logic [1:0] OP_RESTART = 2'd3;

	localparam logic [2:0] FACE_PX = 3'd0;
	localparam logic [2:0] FACE_NX = 3'd1;
	localparam logic [2:0] FACE_PY = 3'd2;
	localparam logic [2:0] FACE_NY = 3'd3;
	localparam logic [2:0] FACE_PZ = 3'd4;
	localparam logic [2:0] FACE_NZ = 3'd5;

	localparam logic [1:0] CORNER_LAST = 2'd3;

	// corner offset {dx, dy, dz} of corner c on face f
	function automatic logic [2:0] corner_ofs(input logic [2:0] f, input logic [1:0] c);
		logic [11:0] row;
		begin
			case (f)
				FACE_PX: row = {3'b100, 3'b110, 3'b111, 3'b101};
				FACE_NX: row = {3'b001, 3'b011, 3'b010, 3'b000};
				FACE_PY: row = {3'b011, 3'b111, 3'b110, 3'b010};
				FACE_NY: row = {3'b000, 3'b100, 3'b101, 3'b001};
				FACE_PZ: row = {3'b001, 3'b101, 3'b111, 3'b011};
				FACE_NZ: row = {3'b100, 3'b000, 3'b010, 3'b110};
				default: row = '0;
			endcase
			case (c)
				2'd0:    corner_ofs = row[11:9];
				2'd1:    corner_ofs = row[8:6];
				2'd2:    corner_ofs = row[5:3];
				default: corner_ofs = row[2:0];
			endcase
		end
	endfunction

	// lowest face whose bit is set
	function automatic logic [2:0] first_face(input logic [5:0] m);
		logic [2:0] r;
		begin
			r = '0;
			for (int i = 5; i >= 0; i--) begin
				if (m[i]) r = 3'(i);
			end
			first_face = r;
		end
	endfunction

	function automatic logic in_chunk(input logic [4:0] x, input logic [4:0] y,
		input logic [4:0] z);
		in_chunk = (int'(x) < SIZE_X) && (int'(y) < SIZE_Y) && (int'(z) < SIZE_Z);
	endfunction

	function automatic logic [RA_W-1:0] row_of(input int zz, input int yy);
		row_of = RA_W'(zz * SIZE_Y + yy);
	endfunction

endpackage
`default_nettype wire

/* hdl/voxel_face_culling_mesher_core.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// voxel_face_culling_mesher_core
// Voxel occupancy store with culled face meshing, four vertices per open face.
// ----------------------------------------------------------------------------
// Occupancy lives in one synchronous RAM of SIZE_Y*SIZE_Z rows, each row
// SIZE_X voxels wide. A write word reads the row and writes it back. A mesh
// word reads the center row and the four y/z neighbor rows through the single
// read port, then emits one vertex per cycle while the output is not stalled,
// four per open face and up to 24 in all; an empty or hidden voxel gives a
// single empty word. A clear word, and reset, run a clearing pass that writes
// one row per cycle over all SIZE_Y*SIZE_Z rows, during which no input word is
// taken. Results sit in an output register, so the next input word is taken
// while the last vertex still waits.
module voxel_face_culling_mesher_core
	import vfcm_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire logic [1:0]       operation,
	input  wire logic [4:0]       pos_x,
	input  wire logic [4:0]       pos_y,
	input  wire logic [4:0]       pos_z,
	input  wire logic             solid,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output logic [5:0]            vert_x,
	output logic [5:0]            vert_y,
	output logic [5:0]            vert_z,
	output logic [2:0]            face,
	output logic [1:0]            corner,
	output logic [CNT_W-1:0]      vertex_number,
	output logic                  face_valid,
	output logic                  last
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_WRD  = 3'd1;
	localparam logic [2:0] S_WWR  = 3'd2;
	localparam logic [2:0] S_MRD  = 3'd3;
	localparam logic [2:0] S_MWT  = 3'd4;
	localparam logic [2:0] S_PREP = 3'd5;
	localparam logic [2:0] S_EMIT = 3'd6;
	localparam logic [2:0] S_CLR  = 3'd7;

	localparam logic [2:0] RK_LAST = 3'd4;

	logic [2:0]        state_q;
	logic [4:0]        x_q, y_q, z_q;
	logic              solid_q;
	logic [2:0]        rk_q;
	logic              rv_s1;
	logic [2:0]        rk_s1;
	logic              solid_c_q;
	logic [5:0]        open_q;
	logic [2:0]        f_q;
	logic [1:0]        c_q;
	logic [RA_W-1:0]   clr_q;
	logic [CNT_W-1:0]  count_q;

	logic [SIZE_X-1:0] occ_q [ROWS];
	logic [SIZE_X-1:0] rd_q;

	logic              out_valid_q;
	logic [5:0]        vx_q, vy_q, vz_q;
	logic [2:0]        face_q;
	logic [1:0]        corner_q;
	logic [CNT_W-1:0]  vnum_q;
	logic              fvalid_q, last_q;

	logic              accept;
	logic              out_free;
	logic              center_in;
	logic [RA_W-1:0]   ra, wa;
	logic              we;
	logic [SIZE_X-1:0] wd, wrow;
	logic [XI_W-1:0]   xi, xi_p, xi_m;
	logic [5:0]        rem;
	logic [2:0]        ofs;

	assign in_ready  = (state_q == S_IDLE);
	assign accept    = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;
	assign center_in = in_chunk(x_q, y_q, z_q);

	assign xi   = XI_W'(x_q);
	assign xi_p = XI_W'({1'b0, x_q} + 6'd1);
	assign xi_m = XI_W'({1'b0, x_q} - 6'd1);

	// faces above the current one that are still open
	assign rem = open_q & (6'b111110 << f_q);
	assign ofs = corner_ofs(f_q, c_q);

	always_comb begin
		case (rk_q)
			3'd1:    ra = row_of(int'(z_q), int'(y_q) + 1);
			3'd2:    ra = row_of(int'(z_q), int'(y_q) - 1);
			3'd3:    ra = row_of(int'(z_q) + 1, int'(y_q));
			3'd4:    ra = row_of(int'(z_q) - 1, int'(y_q));
			default: ra = row_of(int'(z_q), int'(y_q));
		endcase
		if (state_q == S_WRD) ra = row_of(int'(z_q), int'(y_q));
	end

	always_comb begin
		wrow     = rd_q;
		wrow[xi] = solid_q;
	end

	assign we = (state_q == S_WWR) || (state_q == S_CLR);
	assign wa = (state_q == S_CLR) ? clr_q : row_of(int'(z_q), int'(y_q));
	assign wd = (state_q == S_CLR) ? '0 : wrow;

	always_ff @(posedge clk) begin
		if (we) occ_q[wa] <= wd;
		rd_q <= occ_q[ra];
	end

	// capture center and neighbor bits as the rows return
	always_ff @(posedge clk) begin
		if (rv_s1) begin
			case (rk_s1)
				3'd0: begin
					solid_c_q <= center_in && rd_q[xi];
					open_q[FACE_PX] <= !((int'(x_q) + 1 < SIZE_X) && rd_q[xi_p]);
					open_q[FACE_NX] <= !((x_q != 5'd0) && rd_q[xi_m]);
				end
				3'd1: open_q[FACE_PY] <= !((int'(y_q) + 1 < SIZE_Y) && rd_q[xi]);
				3'd2: open_q[FACE_NY] <= !((y_q != 5'd0) && rd_q[xi]);
				3'd3: open_q[FACE_PZ] <= !((int'(z_q) + 1 < SIZE_Z) && rd_q[xi]);
				default: open_q[FACE_NZ] <= !((z_q != 5'd0) && rd_q[xi]);
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			x_q     <= pos_x;
			y_q     <= pos_y;
			z_q     <= pos_z;
			solid_q <= solid;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLR;
			clr_q       <= '0;
			count_q     <= '0;
			rk_q        <= '0;
			rv_s1       <= 1'b0;
			rk_s1       <= '0;
			f_q         <= '0;
			c_q         <= '0;
		end else begin
			rv_s1 <= (state_q == S_MRD);
			rk_s1 <= rk_q;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						case (operation)
							OP_WRITE: begin
								if (in_chunk(pos_x, pos_y, pos_z)) state_q <= S_WRD;
							end
							OP_MESH: begin
								rk_q    <= '0;
								state_q <= S_MRD;
							end
							OP_CLEAR: begin
								clr_q   <= '0;
								count_q <= '0;
								state_q <= S_CLR;
							end
							default: count_q <= '0;
						endcase
					end
				end
				S_WRD: state_q <= S_WWR;
				S_WWR: state_q <= S_IDLE;
				S_MRD: begin
					rk_q <= rk_q + 3'd1;
					if (rk_q == RK_LAST) state_q <= S_MWT;
				end
				S_MWT: state_q <= S_PREP;
				S_PREP: begin
					f_q     <= first_face(open_q);
					c_q     <= '0;
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (out_free) begin
						if (!solid_c_q || open_q == 6'd0) begin
							state_q <= S_IDLE;
						end else begin
							count_q <= count_q + CNT_W'(1);
							if (c_q == CORNER_LAST) begin
								if (rem == 6'd0) state_q <= S_IDLE;
								else begin
									f_q <= first_face(rem);
									c_q <= '0;
								end
							end else begin
								c_q <= c_q + 2'd1;
							end
						end
					end
				end
				S_CLR: begin
					if (int'(clr_q) == ROWS - 1) state_q <= S_IDLE;
					else clr_q <= clr_q + RA_W'(1);
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// load a new word when emitting, drop the old one once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_EMIT && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output word register
	always_ff @(posedge clk) begin
		if (state_q == S_EMIT && out_free) begin
			if (!solid_c_q || open_q == 6'd0) begin
				vx_q     <= '0;
				vy_q     <= '0;
				vz_q     <= '0;
				face_q   <= '0;
				corner_q <= '0;
				vnum_q   <= '0;
				fvalid_q <= 1'b0;
				last_q   <= 1'b1;
			end else begin
				vx_q     <= {1'b0, x_q} + {5'd0, ofs[2]};
				vy_q     <= {1'b0, y_q} + {5'd0, ofs[1]};
				vz_q     <= {1'b0, z_q} + {5'd0, ofs[0]};
				face_q   <= f_q;
				corner_q <= c_q;
				vnum_q   <= count_q;
				fvalid_q <= 1'b1;
				last_q   <= (c_q == CORNER_LAST) && (rem == 6'd0);
			end
		end
	end

	assign out_valid     = out_valid_q;
	assign vert_x        = vx_q;
	assign vert_y        = vy_q;
	assign vert_z        = vz_q;
	assign face          = face_q;
	assign corner        = corner_q;
	assign vertex_number = vnum_q;
	assign face_valid    = fvalid_q;
	assign last          = last_q;

endmodule
`default_nettype wire

/* hdl/vfcm_checker.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// vfcm_checker
// Port-level checks on the result stream of the voxel face culling mesher.
// ----------------------------------------------------------------------------
module vfcm_checker
	import vfcm_pkg::*;
(
	input wire logic             clk,
	input wire logic             arst_n,
	input wire logic             out_valid,
	input wire logic             out_ready,
	input wire logic [5:0]       vert_x,
	input wire logic [5:0]       vert_y,
	input wire logic [5:0]       vert_z,
	input wire logic [2:0]       face,
	input wire logic [1:0]       corner,
	input wire logic [CNT_W-1:0] vertex_number,
	input wire logic             face_valid,
	input wire logic             last
);

	// hold a stalled word
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(vert_x) && $stable(vert_y)
		&& $stable(vert_z) && $stable(face) && $stable(corner)
		&& $stable(vertex_number) && $stable(face_valid) && $stable(last))
		else $error("stalled result word changed");

	a_empty_word: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !face_valid |-> last && vertex_number == '0 && corner == '0
		&& face == '0)
		else $error("empty result word malformed");

	a_last_corner: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && face_valid && last |-> corner == CORNER_LAST)
		else $error("mesh item ended inside a face");

	// inside one mesh item the next vertex follows at once, one number up
	a_next_vertex: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && face_valid && !last |=> out_valid && face_valid
		&& vertex_number == CNT_W'($past(vertex_number) + 1'b1))
		else $error("vertex sequence broken");

endmodule

bind voxel_face_culling_mesher_core vfcm_checker u_vfcm_checker (.*);
`default_nettype wire

/* dv/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for voxel_face_culling_mesher_core. Words go in from a
// pending queue, a local predictor of the occupancy store and vertex count
// builds the vertex stream each accepted word should produce, and every
// vertex word that comes out is compared field by field with the oldest one.
// ----------------------------------------------------------------------------
module tb
	import vfcm_pkg::*;
;

	localparam int NUM_FACES  = 6;
	localparam int NUM_CORNER = 4;
	localparam int CELLS      = SIZE_X * SIZE_Y * SIZE_Z;
	localparam int HOLD_LEN   = 400;
	localparam int DRAIN_CYC  = 64;
	localparam int CYCLE_CAP  = 2000000;

	// {dx, dy, dz} per corner, face +x corner 0 in the top bits
	localparam logic [71:0] CORNER_BITS = {
		12'b100_110_111_101, 12'b001_011_010_000, 12'b011_111_110_010,
		12'b000_100_101_001, 12'b001_101_111_011, 12'b100_000_010_110
	};

	typedef struct packed {
		logic [1:0] op;
		logic [4:0] x;
		logic [4:0] y;
		logic [4:0] z;
		logic       s;
	} word_t;

	typedef struct packed {
		logic [5:0]       vx;
		logic [5:0]       vy;
		logic [5:0]       vz;
		logic [2:0]       fc;
		logic [1:0]       cn;
		logic [CNT_W-1:0] num;
		logic             valid;
		logic             last;
	} vertex_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             in_valid = 1'b0;
	logic             in_ready;
	logic [1:0]       operation = OP_WRITE;
	logic [4:0]       pos_x = '0;
	logic [4:0]       pos_y = '0;
	logic [4:0]       pos_z = '0;
	logic             solid = 1'b0;
	logic             out_valid;
	logic             out_ready = 1'b0;
	logic [5:0]       vert_x;
	logic [5:0]       vert_y;
	logic [5:0]       vert_z;
	logic [2:0]       face;
	logic [1:0]       corner;
	logic [CNT_W-1:0] vertex_number;
	logic             face_valid;
	logic             last;

	voxel_face_culling_mesher_core dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.operation     (operation),
		.pos_x         (pos_x),
		.pos_y         (pos_y),
		.pos_z         (pos_z),
		.solid         (solid),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.vert_x        (vert_x),
		.vert_y        (vert_y),
		.vert_z        (vert_z),
		.face          (face),
		.corner        (corner),
		.vertex_number (vertex_number),
		.face_valid    (face_valid),
		.last          (last)
	);

	// predicted state of the block
	bit   [CELLS-1:0] occ_map = '0;
	logic [CNT_W-1:0] vtx_count = '0;

	word_t   pending_words[$];
	vertex_t expected_vertices[$];
	word_t   drv_word;
	vertex_t head_vtx;

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	bit hold_pending = 1'b0;
	int hold_cycles = 0;
	bit in_taken = 1'b0;

	int err_count = 0;
	int cycle_count = 0;
	int words_taken = 0;
	int vertices_seen = 0;
	int open_meshes = 0;
	int count_wraps = 0;

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic int cell_index(input int x, input int y, input int z);
		return (z * SIZE_Y + y) * SIZE_X + x;
	endfunction

	function automatic bit solid_at(input int x, input int y, input int z);
		if (x < 0 || x >= SIZE_X || y < 0 || y >= SIZE_Y || z < 0 || z >= SIZE_Z)
			return 1'b0;
		return occ_map[cell_index(x, y, z)];
	endfunction

	// update the local store and queue the vertices one accepted word makes
	task automatic predict_word(input logic [1:0] op, input logic [4:0] x,
		input logic [4:0] y, input logic [4:0] z, input logic s);
		logic [5:0] open;
		logic [2:0] fc;
		logic [2:0] ofs;
		vertex_t    v;
		int         nx, ny, nz;
		int         last_face;
		int         fi, c;
		open = '0;
		last_face = 0;
		case (op)
			OP_WRITE: begin
				if (int'(x) < SIZE_X && int'(y) < SIZE_Y && int'(z) < SIZE_Z)
					occ_map[cell_index(x, y, z)] = s;
			end
			OP_CLEAR: begin
				occ_map = '0;
				vtx_count = '0;
			end
			OP_RESTART: begin
				vtx_count = '0;
			end
			default: begin
				if (solid_at(x, y, z)) begin
					for (fi = 0; fi < NUM_FACES; fi++) begin
						fc = 3'(fi);
						nx = x;
						ny = y;
						nz = z;
						case (fc)
							FACE_PX: nx = nx + 1;
							FACE_NX: nx = nx - 1;
							FACE_PY: ny = ny + 1;
							FACE_NY: ny = ny - 1;
							FACE_PZ: nz = nz + 1;
							default: nz = nz - 1;
						endcase
						open[fi] = !solid_at(nx, ny, nz);
						if (open[fi])
							last_face = fi;
					end
				end
				if (open == '0) begin
					v = '0;
					v.last = 1'b1;
					expected_vertices = {expected_vertices, v};
				end else begin
					open_meshes++;
					for (fi = 0; fi < NUM_FACES; fi++) begin
						if (open[fi]) begin
							for (c = 0; c < NUM_CORNER; c++) begin
								ofs = CORNER_BITS[(23 - (fi * NUM_CORNER + c)) * 3 +: 3];
								v.vx    = {1'b0, x} + 6'(ofs[2]);
								v.vy    = {1'b0, y} + 6'(ofs[1]);
								v.vz    = {1'b0, z} + 6'(ofs[0]);
								v.fc    = 3'(fi);
								v.cn    = 2'(c);
								v.num   = vtx_count;
								v.valid = 1'b1;
								v.last  = (fi == last_face) && (c == NUM_CORNER - 1);
								expected_vertices = {expected_vertices, v};
								vtx_count = vtx_count + 1'b1;
								if (vtx_count == '0)
									count_wraps++;
							end
						end
					end
				end
			end
		endcase
	endtask

	task automatic check_field(input string name, input int unsigned want,
		input int unsigned got);
		if (want != got) begin
			err_count++;
			$error("%s: expected %0d, actual %0d", name, want, got);
		end
	endtask

	// sample both channels at the rising edge
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		in_taken <= in_valid && in_ready;
		if (in_valid && in_ready) begin
			words_taken++;
			predict_word(operation, pos_x, pos_y, pos_z, solid);
		end
		if (out_valid && out_ready) begin
			vertices_seen++;
			if (expected_vertices.size() == 0) begin
				err_count++;
				$error("vertex word with no prediction waiting");
			end else begin
				head_vtx = expected_vertices.pop_front();
				check_field("vert_x", head_vtx.vx, vert_x);
				check_field("vert_y", head_vtx.vy, vert_y);
				check_field("vert_z", head_vtx.vz, vert_z);
				check_field("face", head_vtx.fc, face);
				check_field("corner", head_vtx.cn, corner);
				check_field("vertex_number", head_vtx.num, vertex_number);
				check_field("face_valid", head_vtx.valid, face_valid);
				check_field("last", head_vtx.last, last);
			end
		end
		if (cycle_count >= CYCLE_CAP) begin
			$display("Timeout after %0d cycles", cycle_count);
			$display("Mismatches found");
			$finish;
		end
	end

	// input side: hold the word until taken, then advance or idle
	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || in_taken) begin
			if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				drv_word = pending_words.pop_front();
				operation <= drv_word.op;
				pos_x     <= drv_word.x;
				pos_y     <= drv_word.y;
				pos_z     <= drv_word.z;
				solid     <= drv_word.s;
				in_valid  <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// output side: random stalls, or one long hold-off on request
	always @(negedge clk) begin
		if (hold_pending && hold_cycles < HOLD_LEN) begin
			out_ready <= 1'b0;
			hold_cycles <= hold_cycles + 1;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
			if (!hold_pending)
				hold_cycles <= 0;
		end
	end

	task automatic push_word(input logic [1:0] op, input int x, input int y,
		input int z, input logic s);
		word_t w;
		w.op = op;
		w.x  = 5'(x);
		w.y  = 5'(y);
		w.z  = 5'(z);
		w.s  = s;
		pending_words = {pending_words, w};
	endtask

	// mostly writes and meshes clustered in a small box so neighbors really hide faces, with some clears and restarts
	task automatic push_random(input int count);
		int bx, by, bz;
		int r, i;
		logic [1:0] op;
		bx = 0;
		by = 0;
		bz = 0;
		for (i = 0; i < count; i++) begin
			if (i % 16 == 0) begin
				if ($urandom_range(3) == 0) begin
					bx = $urandom_range(1) * (SIZE_X - 4);
					by = $urandom_range(1) * (SIZE_Y - 4);
					bz = $urandom_range(1) * (SIZE_Z - 4);
				end else begin
					bx = $urandom_range(SIZE_X - 4);
					by = $urandom_range(SIZE_Y - 4);
					bz = $urandom_range(SIZE_Z - 4);
				end
			end
			r = $urandom_range(99);
			if (r < 45)
				op = OP_WRITE;
			else if (r < 90)
				op = OP_MESH;
			else if (r < 93)
				op = OP_CLEAR;
			else if (r < 97)
				op = OP_RESTART;
			else
				op = OP_MESH;
			if (r >= 97)
				push_word(op, $urandom_range(31), $urandom_range(31),
					$urandom_range(31), 1'($urandom));
			else
				push_word(op, bx + $urandom_range(3), by + $urandom_range(3),
					bz + $urandom_range(3), ($urandom_range(99) < 75));
		end
	endtask

	task automatic wait_drained();
		while (pending_words.size() != 0 || in_valid || expected_vertices.size() != 0)
			@(posedge clk);
	endtask

	task automatic run_phase(input int send_pct, input int recv_pct, input int count);
		send_idle_pct = send_pct;
		recv_stall_pct = recv_pct;
		push_random(count);
		wait_drained();
	endtask

	initial begin
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// corner voxel alone: all six faces, three neighbors outside the chunk
		push_word(OP_WRITE, 0, 0, 0, 1'b1);
		push_word(OP_MESH, 0, 0, 0, 1'b0);
		// neighbor on +x hides one face on each
		push_word(OP_WRITE, 1, 0, 0, 1'b1);
		push_word(OP_MESH, 0, 0, 0, 1'b1);
		push_word(OP_MESH, 1, 0, 0, 1'b0);
		// far corner drives vertex positions to 32
		push_word(OP_WRITE, 31, 31, 31, 1'b1);
		push_word(OP_MESH, 31, 31, 31, 1'b0);
		// empty voxel
		push_word(OP_MESH, 5, 5, 5, 1'b1);
		// fully hidden voxel
		push_word(OP_WRITE, 10, 10, 10, 1'b1);
		push_word(OP_WRITE, 11, 10, 10, 1'b1);
		push_word(OP_WRITE, 9, 10, 10, 1'b1);
		push_word(OP_WRITE, 10, 11, 10, 1'b1);
		push_word(OP_WRITE, 10, 9, 10, 1'b1);
		push_word(OP_WRITE, 10, 10, 11, 1'b1);
		push_word(OP_WRITE, 10, 10, 9, 1'b1);
		push_word(OP_MESH, 10, 10, 10, 1'b0);
		// restart numbering, then erase a voxel by writing zero
		push_word(OP_RESTART, 0, 0, 0, 1'b0);
		push_word(OP_MESH, 0, 0, 0, 1'b0);
		push_word(OP_WRITE, 0, 0, 0, 1'b0);
		push_word(OP_MESH, 0, 0, 0, 1'b0);
		// clear wipes store and count
		push_word(OP_CLEAR, 31, 31, 31, 1'b1);
		push_word(OP_MESH, 1, 0, 0, 1'b0);
		push_word(OP_MESH, 31, 31, 31, 1'b1);
		wait_drained();

		// long output hold-off while words keep coming, so the input backs up
		send_idle_pct = 0;
		recv_stall_pct = 0;
		push_random(60);
		hold_pending = 1'b1;
		while (hold_cycles < HOLD_LEN)
			@(posedge clk);
		hold_pending = 1'b0;
		wait_drained();

		run_phase(0, 0, 110);
		run_phase(66, 0, 110);
		run_phase(0, 66, 110);
		run_phase(33, 33, 110);

		repeat (DRAIN_CYC) @(posedge clk);
		$display("Run took %0d input words and checked %0d vertex words over %0d cycles",
			words_taken, vertices_seen, cycle_count);
		$display("%0d meshes had open faces; vertex count wrapped %0d time(s)",
			open_meshes, count_wraps);
		if (err_count == 0 && expected_vertices.size() == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule

/* sim.f */
hdl/vfcm_pkg.sv
hdl/voxel_face_culling_mesher_core.sv
hdl/vfcm_checker.sv
dv/tb.sv
